>>> hdl/eq_pkg.sv
// ----------------------------------------------------------------------------
// eq_pkg: shared types and constants for the Euler to quaternion converter
// Fixed-point widths, CORDIC arctangent table and the Q30 rounding multiply.
// ----------------------------------------------------------------------------
package eq_pkg;

  localparam int ANGLE_W      = 19;   // input angle, Q16 radians
  localparam int Z_W          = 34;   // CORDIC angle / vector path, Q30
  localparam int SC_W         = 32;   // sine / cosine / products, Q30
  localparam int Q_W          = 16;   // output component, Q1.15
  localparam int CORDIC_STEPS = 30;
  localparam int SINCOS_LAT   = CORDIC_STEPS + 2;  // fold + iterations + sign fix
  localparam int QUAT_LAT     = 3;                 // pair mul, triple mul, sum
  localparam int PIPE_LAT     = SINCOS_LAT + QUAT_LAT;
  localparam int IN_TDATA_W   = 64;
  localparam int OUT_TDATA_W  = 64;

  localparam logic signed [Z_W-1:0] Q30_HALF_PI = Z_W'(64'sd1686629713);
  localparam logic signed [Z_W-1:0] Q30_PI      = Z_W'(64'sd3373259426);
  localparam logic signed [Z_W-1:0] Q30_GAIN    = Z_W'(64'sd652032874);

  localparam logic signed [Z_W-1:0] ATAN_Q30 [CORDIC_STEPS] = '{
    Z_W'(843314857), Z_W'(497837829), Z_W'(263043837), Z_W'(133525159),
    Z_W'(67021687),  Z_W'(33543516),  Z_W'(16775851),  Z_W'(8388437),
    Z_W'(4194283),   Z_W'(2097149),   Z_W'(1048576),   Z_W'(524288),
    Z_W'(262144),    Z_W'(131072),    Z_W'(65536),     Z_W'(32768),
    Z_W'(16384),     Z_W'(8192),      Z_W'(4096),      Z_W'(2048),
    Z_W'(1024),      Z_W'(512),       Z_W'(256),       Z_W'(128),
    Z_W'(64),        Z_W'(32),        Z_W'(16),        Z_W'(8),
    Z_W'(4),         Z_W'(2)
  };

  typedef logic signed [SC_W-1:0] sc_t;

  // half-angle sine and cosine of all three axes
  typedef struct packed {
    sc_t cy;
    sc_t sy;
    sc_t cp;
    sc_t sp;
    sc_t cr;
    sc_t sr;
  } trig_t;

  // Q30 x Q30 -> Q30, round half up, floor shift
  function automatic sc_t mul_q30(input sc_t a, input sc_t b);
    logic signed [2*SC_W-1:0] p;
    p = (2*SC_W)'(a) * (2*SC_W)'(b) + ((2*SC_W)'(1) <<< 29);
    return p[30 +: SC_W];
  endfunction

endpackage

>>> hdl/eq_sincos.sv
// ----------------------------------------------------------------------------
// eq_sincos: pipelined half-angle sine/cosine
// Quadrant fold, one CORDIC iteration per stage, sign fix on the last stage.
// ----------------------------------------------------------------------------
module eq_sincos
  import eq_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [ANGLE_W-1:0] angle,
  output sc_t                       cos_q30,
  output sc_t                       sin_q30
);

  logic signed [Z_W-1:0] half_ang;
  logic signed [Z_W-1:0] x_r [CORDIC_STEPS+1];
  logic signed [Z_W-1:0] y_r [CORDIC_STEPS+1];
  logic signed [Z_W-1:0] z_r [CORDIC_STEPS+1];
  logic                  flip_r [CORDIC_STEPS+1];
  logic signed [Z_W-1:0] x_neg;
  logic signed [Z_W-1:0] y_neg;
  sc_t                   cos_r, sin_r;

  // raw/2 in Q30 is raw shifted up by 13
  assign half_ang = {{(Z_W-ANGLE_W-13){angle[ANGLE_W-1]}}, angle, 13'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= Q30_GAIN;
      y_r[0] <= '0;
      if (half_ang > Q30_HALF_PI) begin
        z_r[0]    <= half_ang - Q30_PI;
        flip_r[0] <= 1'b1;
      end else if (half_ang < -Q30_HALF_PI) begin
        z_r[0]    <= half_ang + Q30_PI;
        flip_r[0] <= 1'b1;
      end else begin
        z_r[0]    <= half_ang;
        flip_r[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        flip_r[i+1] <= flip_r[i];
        if (!z_r[i][Z_W-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATAN_Q30[i];
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATAN_Q30[i];
        end
      end
    end
  end

  // folded angles come back with both signs inverted
  assign x_neg = flip_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
  assign y_neg = flip_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= x_neg[SC_W-1:0];
      sin_r <= y_neg[SC_W-1:0];
    end
  end

  assign cos_q30 = cos_r;
  assign sin_q30 = sin_r;

endmodule

>>> hdl/eq_quat.sv
// ----------------------------------------------------------------------------
// eq_quat: quaternion assembly
// Pair products, triple products, then sum, round to Q15 and saturate.
// ----------------------------------------------------------------------------
module eq_quat
  import eq_pkg::*;
(
  input  logic                   clk,
  input  logic                   en,
  input  trig_t                  trig,
  output logic signed [Q_W-1:0]  quat_x,
  output logic signed [Q_W-1:0]  quat_y,
  output logic signed [Q_W-1:0]  quat_z,
  output logic signed [Q_W-1:0]  quat_w
);

  localparam int SUM_W = SC_W + 1;

  sc_t srcp_r, crsp_r, crcp_r, srsp_r, cy_r, sy_r;
  sc_t t_srcpcy_r, t_crspsy_r, t_crspcy_r, t_srcpsy_r;
  sc_t t_crcpsy_r, t_srspcy_r, t_crcpcy_r, t_srspsy_r;
  logic signed [SUM_W-1:0] sum_x, sum_y, sum_z, sum_w;
  logic signed [Q_W-1:0]   qx_r, qy_r, qz_r, qw_r;

  function automatic logic signed [Q_W-1:0] to_q15(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W:0]      rv;
    logic signed [SUM_W-15:0]   r;
    rv = (SUM_W+1)'(v) + (SUM_W+1)'(1 << 14);
    r  = rv[SUM_W:15];
    if (r > (SUM_W-14)'(32767))
      return Q_W'(32767);
    else if (r < -(SUM_W-14)'(32768))
      return Q_W'(-32768);
    else
      return r[Q_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      srcp_r <= mul_q30(trig.sr, trig.cp);
      crsp_r <= mul_q30(trig.cr, trig.sp);
      crcp_r <= mul_q30(trig.cr, trig.cp);
      srsp_r <= mul_q30(trig.sr, trig.sp);
      cy_r   <= trig.cy;
      sy_r   <= trig.sy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_srcpcy_r <= mul_q30(srcp_r, cy_r);
      t_crspsy_r <= mul_q30(crsp_r, sy_r);
      t_crspcy_r <= mul_q30(crsp_r, cy_r);
      t_srcpsy_r <= mul_q30(srcp_r, sy_r);
      t_crcpsy_r <= mul_q30(crcp_r, sy_r);
      t_srspcy_r <= mul_q30(srsp_r, cy_r);
      t_crcpcy_r <= mul_q30(crcp_r, cy_r);
      t_srspsy_r <= mul_q30(srsp_r, sy_r);
    end
  end

  assign sum_x = SUM_W'(t_srcpcy_r) - SUM_W'(t_crspsy_r);
  assign sum_y = SUM_W'(t_crspcy_r) + SUM_W'(t_srcpsy_r);
  assign sum_z = SUM_W'(t_crcpsy_r) - SUM_W'(t_srspcy_r);
  assign sum_w = SUM_W'(t_crcpcy_r) + SUM_W'(t_srspsy_r);

  always_ff @(posedge clk) begin
    if (en) begin
      qx_r <= to_q15(sum_x);
      qy_r <= to_q15(sum_y);
      qz_r <= to_q15(sum_z);
      qw_r <= to_q15(sum_w);
    end
  end

  assign quat_x = qx_r;
  assign quat_y = qy_r;
  assign quat_z = qz_r;
  assign quat_w = qw_r;

endmodule

>>> hdl/euler_to_quaternion.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion: yaw/pitch/roll (ZYX) to unit quaternion, Q1.15
// Pipeline from input beat to output beat: fold, 30 CORDIC stages,
//   sign fix, two multiply stages, sum/round/saturate.
// Throughput: one beat per cycle; a stalled output holds the whole pipeline.
// Reset: synchronous rst_n clears valid bits and the input skid valid flag.
// ----------------------------------------------------------------------------
module euler_to_quaternion
  import eq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [18:0] yaw_angle, [37:19] pitch_angle, [56:38] roll_angle, [63:57] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [15:0] quat_x, [31:16] quat_y, [47:32] quat_z, [63:48] quat_w
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int ANG3_W = 3 * ANGLE_W;

  logic                  pipe_en;
  logic                  in_fire;
  logic                  skid_v_r, skid_v_nxt;
  logic [ANG3_W-1:0]     skid_data_r;
  logic [ANG3_W-1:0]     src_data;
  logic                  src_valid;
  logic                  vld_r [PIPE_LAT];
  trig_t                 trig;
  logic signed [Q_W-1:0] quat_x, quat_y, quat_z, quat_w;

  // whole pipeline advances whenever the output register is free
  assign pipe_en   = !vld_r[PIPE_LAT-1] || out_tready;
  assign in_tready = !skid_v_r;
  assign in_fire   = in_tvalid && in_tready;

  assign src_valid = skid_v_r || in_fire;
  assign src_data  = skid_v_r ? skid_data_r : in_tdata[ANG3_W-1:0];

  // beat taken while stalled parks in the skid register
  always_comb begin
    skid_v_nxt = skid_v_r;
    if (pipe_en)
      skid_v_nxt = 1'b0;
    else if (in_fire)
      skid_v_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else begin
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!pipe_en && in_fire) begin
      skid_data_r <= in_tdata[ANG3_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PIPE_LAT; k++) vld_r[k] <= 1'b0;
    end else if (pipe_en) begin
      vld_r[0] <= src_valid;
      for (int k = 1; k < PIPE_LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  eq_sincos u_yaw (
    .clk     (clk),
    .en      (pipe_en),
    .angle   (src_data[0 +: ANGLE_W]),
    .cos_q30 (trig.cy),
    .sin_q30 (trig.sy)
  );

  eq_sincos u_pitch (
    .clk     (clk),
    .en      (pipe_en),
    .angle   (src_data[ANGLE_W +: ANGLE_W]),
    .cos_q30 (trig.cp),
    .sin_q30 (trig.sp)
  );

  eq_sincos u_roll (
    .clk     (clk),
    .en      (pipe_en),
    .angle   (src_data[2*ANGLE_W +: ANGLE_W]),
    .cos_q30 (trig.cr),
    .sin_q30 (trig.sr)
  );

  eq_quat u_quat (
    .clk    (clk),
    .en     (pipe_en),
    .trig   (trig),
    .quat_x (quat_x),
    .quat_y (quat_y),
    .quat_z (quat_z),
    .quat_w (quat_w)
  );

  assign out_tvalid = vld_r[PIPE_LAT-1];
  assign out_tdata  = {quat_w, quat_z, quat_y, quat_x};

  // stalled beat must land in the skid register
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !pipe_en |=> skid_v_r)
    else $error("accepted beat not parked while stalled");

  // parked beat holds until the pipeline moves
  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !pipe_en |=> skid_v_r && $stable(skid_data_r))
    else $error("skid register lost or changed its beat");

  // a beat entering the pipeline shows up in the first valid bit
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_en && src_valid |=> vld_r[0])
    else $error("beat dropped at pipeline entry");

  // skid drains before new input is taken
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> !in_fire)
    else $error("input taken while skid register full");

endmodule

>>> test/quat_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quat_checker: scoreboard for the Euler to quaternion converter
// Watches both stream channels. Every accepted input beat is run through a
// bit-exact model (half angle, quadrant fold, 30-step CORDIC, rounded Q30
// triple products, Q15 round and saturate) and the expected quaternion is
// queued. Every accepted output beat is compared field by field against the
// oldest queued quaternion.
// ----------------------------------------------------------------------------
module quat_checker
  import eq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // [18:0] yaw_angle, [37:19] pitch_angle, [56:38] roll_angle, [63:57] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // [15:0] quat_x, [31:16] quat_y, [47:32] quat_z, [63:48] quat_w
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     errors,
  output int                     pending
);

  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint GAIN_Q30    = 64'sd652032874;
  localparam longint ROUND_Q30   = 64'sd536870912;  // 2^29
  localparam longint ROUND_Q15   = 64'sd16384;      // 2^14
  localparam int     STEPS       = 30;

  localparam longint ARCTAN_Q30 [STEPS] = '{
    843314857, 497837829, 263043837, 133525159, 67021687,
    33543516,  16775851,  8388437,   4194283,   2097149,
    1048576,   524288,    262144,    131072,    65536,
    32768,     16384,     8192,      4096,      2048,
    1024,      512,       256,       128,       64,
    32,        16,        8,         4,         2
  };

  // last field (x) in the low bits
  typedef struct packed {
    logic [Q_W-1:0] w;
    logic [Q_W-1:0] z;
    logic [Q_W-1:0] y;
    logic [Q_W-1:0] x;
  } quat_t;

  quat_t expected_quats[$];
  int    error_count = 0;
  int    queued = 0;

  assign errors  = error_count;
  assign pending = queued;

  // cos and sin (Q30) of half the Q16 angle
  function automatic void half_angle_trig(input logic signed [ANGLE_W-1:0] ang,
                                          output longint c, output longint s);
    longint z, x, y, nx;
    bit     flip;
    z    = longint'(ang) * 64'sd8192;
    x    = GAIN_Q30;
    y    = 0;
    flip = 1'b0;
    if (z > HALF_PI_Q30) begin
      z    = z - PI_Q30;
      flip = 1'b1;
    end else if (z < -HALF_PI_Q30) begin
      z    = z + PI_Q30;
      flip = 1'b1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ARCTAN_Q30[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ARCTAN_Q30[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint mul_round_q30(input longint a, input longint b);
    return (a * b + ROUND_Q30) >>> 30;
  endfunction

  function automatic longint triple_q30(input longint a, input longint b, input longint c);
    return mul_round_q30(mul_round_q30(a, b), c);
  endfunction

  function automatic logic [Q_W-1:0] sat_q15(input longint v);
    longint r;
    r = (v + ROUND_Q15) >>> 15;
    if (r > 32767)
      r = 32767;
    if (r < -32768)
      r = -32768;
    return r[Q_W-1:0];
  endfunction

  function automatic quat_t angles_to_quat(input logic [IN_TDATA_W-1:0] beat);
    longint cy, sy, cp, sp, cr, sr;
    quat_t  q;
    half_angle_trig(beat[18:0],  cy, sy);
    half_angle_trig(beat[37:19], cp, sp);
    half_angle_trig(beat[56:38], cr, sr);
    q.x = sat_q15(triple_q30(sr, cp, cy) - triple_q30(cr, sp, sy));
    q.y = sat_q15(triple_q30(cr, sp, cy) + triple_q30(sr, cp, sy));
    q.z = sat_q15(triple_q30(cr, cp, sy) - triple_q30(sr, sp, cy));
    q.w = sat_q15(triple_q30(cr, cp, cy) + triple_q30(sr, sp, sy));
    return q;
  endfunction

  task automatic compare_component(input string name, input logic [Q_W-1:0] want,
                                   input logic [Q_W-1:0] got);
    if (got !== want) begin
      $display("%0t: quat_%s mismatch: expected %0d, actual %0d", $time, name,
               $signed(want), $signed(got));
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    quat_t got, want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        expected_quats.push_back(angles_to_quat(in_tdata));
      if (out_tvalid && out_tready) begin
        got = quat_t'(out_tdata);
        if (expected_quats.size() == 0) begin
          $display("%0t: output beat with nothing expected: expected none, actual %h",
                   $time, out_tdata);
          error_count++;
        end else begin
          want = expected_quats.pop_front();
          compare_component("x", want.x, got.x);
          compare_component("y", want.y, got.y);
          compare_component("z", want.z, got.z);
          compare_component("w", want.w, got.w);
        end
      end
      queued = expected_quats.size();
    end
  end

endmodule

>>> test/euler_to_quaternion_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// euler_to_quaternion_tb: stimulus and verdict for the Euler to quaternion core
// Drives directed angle sets (range extremes, zero, +/-pi, quadrant fold
// edges) and then random sets under three sender/receiver stall profiles.
// Checking is done by quat_checker beside the core.
// ----------------------------------------------------------------------------
module euler_to_quaternion_tb
  import eq_pkg::*;
();

  localparam int DRAIN_CYCLES     = 40;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int RANDOM_PER_PHASE = 245;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX  = 19'h3ffff;   // +4 rad - lsb
  localparam logic [ANGLE_W-1:0] ANGLE_MIN  = 19'h40000;   // -4 rad
  localparam int                 PI_Q16     = 205887;      // largest unfolded
  localparam int                 HALF_PI_Q16 = 102944;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tready = 1'b0;
  logic                   in_tready;
  logic                   out_tvalid;
  logic [OUT_TDATA_W-1:0] out_tdata;
  int                     errors;
  int                     pending;
  int                     send_idle_pct = 0;
  int                     recv_idle_pct = 0;

  euler_to_quaternion uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  quat_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    for (int n = 0; n < CYCLE_LIMIT; n++)
      @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  // one beat, held until accepted; returns on the falling edge after acceptance
  task automatic send_angles(input logic [ANGLE_W-1:0] yaw, input logic [ANGLE_W-1:0] pitch,
                             input logic [ANGLE_W-1:0] roll);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, roll, pitch, yaw};
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [ANGLE_W-1:0] random_angle();
    int v;
    case ($urandom_range(5))
      0, 1: v = int'($urandom());
      2: v = ($urandom_range(1) ? PI_Q16 : -PI_Q16 - 1) + int'($urandom_range(8)) - 4;
      3: v = int'($urandom_range(4095)) - 2048;
      4: v = ($urandom_range(1) ? HALF_PI_Q16 : -HALF_PI_Q16) + int'($urandom_range(64)) - 32;
      default: begin
        case ($urandom_range(3))
          0: v = int'(ANGLE_MAX);
          1: v = -262144;
          2: v = 0;
          default: v = -1;
        endcase
      end
    endcase
    return v[ANGLE_W-1:0];
  endfunction

  task automatic random_phase(input int s_idle, input int r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (RANDOM_PER_PHASE)
      send_angles(random_angle(), random_angle(), random_angle());
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 32;
    recv_idle_pct = 53;
    // identity: w at one saturates
    send_angles(19'd0, 19'd0, 19'd0);
    send_angles(ANGLE_MAX, ANGLE_MAX, ANGLE_MAX);
    send_angles(ANGLE_MIN, ANGLE_MIN, ANGLE_MIN);
    send_angles(ANGLE_MIN, ANGLE_MAX, 19'd0);
    send_angles(19'd0, ANGLE_MIN, ANGLE_MAX);
    send_angles(ANGLE_MAX, 19'd0, ANGLE_MIN);
    // half-turn about one axis puts that component at one
    send_angles(19'd0, 19'd0, 19'(PI_Q16));
    send_angles(19'd0, 19'(PI_Q16), 19'd0);
    send_angles(19'(PI_Q16), 19'd0, 19'd0);
    send_angles(19'd0, 19'd0, 19'(-PI_Q16));
    send_angles(19'(-PI_Q16), 19'(-PI_Q16), 19'd0);
    // at and just past the quadrant fold, then small, half-pi and mixed angles
    send_angles(19'(PI_Q16 + 1), 19'(-PI_Q16 - 1), 19'(PI_Q16 + 1));
    send_angles(19'(-PI_Q16 - 1), 19'(PI_Q16 + 1), 19'(-PI_Q16 - 1));
    send_angles(19'(PI_Q16), 19'(-PI_Q16), 19'(-PI_Q16 - 1));
    send_angles(19'h7ffff, 19'h7ffff, 19'h7ffff);
    send_angles(19'd1, 19'd1, 19'd1);
    send_angles(19'(HALF_PI_Q16), 19'(HALF_PI_Q16), 19'(HALF_PI_Q16));
    send_angles(19'(-HALF_PI_Q16), 19'(HALF_PI_Q16), 19'(-HALF_PI_Q16));
    send_angles(19'h2aaaa, 19'h15555, 19'h55555);

    random_phase(32, 53);
    random_phase(53, 32);
    random_phase(0, 0);
    in_tvalid <= 1'b0;

    while (pending != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
